// ----- hw/rtl/tvap_pkg.sv -----
// ----------------------------------------------------------------------------
// tvap_pkg
// Shared types, constants and helper functions of the artifact palette
// generator pipeline.
// ----------------------------------------------------------------------------
package tvap_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_NOISE      = 3'd0,
    REG_GHOST      = 3'd1,
    REG_SCANLINE   = 3'd2,
    REG_BRIGHTNESS = 3'd3,
    REG_CONTRAST   = 3'd4,
    REG_SATURATION = 3'd5,
    REG_MODE       = 3'd6
  } reg_index_t;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 9;

  // Reset values of the level registers.
  localparam logic [7:0] BrightnessReset = 8'd128;
  localparam logic [7:0] ContrastReset   = 8'd64;
  localparam logic [7:0] SaturationReset = 8'd255;

  // Reciprocals for division by constants. Each is exact over the value
  // range that reaches it.
  localparam logic [20:0] Recip1000 = 21'd1073742;  // ceil(2^30 / 1000)
  localparam int          Shift1000 = 30;
  localparam logic [18:0] Recip255  = 19'd263173;   // ceil(2^26 / 255)
  localparam int          Shift255  = 26;
  localparam logic [7:0]  Recip3    = 8'd171;       // ceil(2^9 / 3)
  localparam int          Shift3    = 9;

  localparam logic [4:0]  RampBias  = 5'd9;
  localparam logic [16:0] RampScale = 17'd125;      // 1000 / 16, times two

  typedef struct packed {
    logic signed [8:0] noise;
    logic signed [8:0] ghost;
    logic signed [7:0] ghost3;
    logic signed [8:0] scanline;
    logic [7:0]        brightness;
    logic [7:0]        contrast;
    logic [7:0]        saturation;
    logic              inverse;
    logic              vibrant;
    logic              scan_en;
  } cfg_t;

  // Color number, ramp level and the index bits that ride along.
  typedef struct packed {
    logic [3:0] c;
    logic [9:0] base;
    logic [3:0] nib;
  } base_out_t;

  // Blended channel quotient magnitudes and signs (red, green, blue).
  typedef struct packed {
    logic [2:0][9:0]    qmag;
    logic [2:0]         neg;
    logic signed [11:0] grey;
    logic [3:0]         nib;
  } blend_out_t;

  // Distance from the base level to the top level of the ramp.
  function automatic logic [9:0] tvap_span(input logic upper, input logic [7:0] con);
    logic [9:0] lo;
    logic [9:0] half;
    lo   = {1'b0, con, 1'b0};
    half = upper ? {3'b000, con[7:1]} : 10'd0;
    return lo + half;
  endfunction

  function automatic logic [7:0] tvap_clamp14(input logic signed [13:0] v);
    logic [7:0] r;
    if (v[13]) begin
      r = 8'd0;
    end else if (v > 14'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] tvap_clamp10(input logic signed [9:0] v);
    logic [7:0] r;
    if (v[9]) begin
      r = 8'd0;
    end else if (v[8]) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/tvap_base.sv -----
// ----------------------------------------------------------------------------
// tvap_base
// Stages one to three: color number, ramp step and the ramp level of the
// color (the divide by 1000 done as a reciprocal multiply).
// ----------------------------------------------------------------------------
module tvap_base
  import tvap_pkg::*;
(
  input  logic       clk,
  input  cfg_t       cfg,
  input  logic [3:1] en,
  input  logic [7:0] idx,
  output base_out_t  out
);

  logic [3:0]  c_in;
  logic [9:0]  span;
  logic [16:0] span_scaled;

  logic [15:0] s1_diff;
  logic [3:0]  s1_c;
  logic [3:0]  s1_nib;

  logic [4:0]  ramp_k;
  logic [20:0] ramp_prod;

  logic [19:0] s2_x;
  logic [3:0]  s2_c;
  logic [3:0]  s2_nib;

  logic [40:0] div_prod;

  // Inverse mode mirrors the low three bits of the color number.
  assign c_in        = cfg.inverse ? {idx[7], ~idx[6:4]} : idx[7:4];
  assign span        = tvap_span(c_in[3], cfg.contrast);
  assign span_scaled = 17'(span) * RampScale;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_diff <= span_scaled[16:1];
      s1_c    <= c_in;
      s1_nib  <= idx[3:0];
    end
  end

  assign ramp_k    = 5'(s1_c[2:0]) + RampBias;
  assign ramp_prod = 21'(s1_diff) * 21'(ramp_k);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_x   <= ramp_prod[19:0];
      s2_c   <= s1_c;
      s2_nib <= s1_nib;
    end
  end

  assign div_prod = 41'(s2_x) * 41'(Recip1000);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      out.base <= div_prod[Shift1000 +: 10];
      out.c    <= s2_c;
      out.nib  <= s2_nib;
    end
  end

endmodule

// ----- hw/rtl/tvap_blend.sv -----
// ----------------------------------------------------------------------------
// tvap_blend
// Stages four and five: channel distance from grey scaled by saturation,
// then the signed divide by 255 as a magnitude reciprocal multiply.
// ----------------------------------------------------------------------------
module tvap_blend
  import tvap_pkg::*;
(
  input  logic       clk,
  input  cfg_t       cfg,
  input  logic [5:4] en,
  input  base_out_t  in,
  output blend_out_t out
);

  logic signed [9:0]  b0;
  logic signed [10:0] basev;
  logic signed [11:0] grey;
  logic [9:0]         span;
  logic [2:0]         chan_bit;
  logic signed [11:0] term [3];
  logic signed [11:0] dch [3];
  logic signed [20:0] prod [3];

  logic signed [20:0] s4_p [3];
  logic signed [11:0] s4_grey;
  logic [3:0]         s4_nib;

  logic [17:0] mag [3];
  logic [36:0] qprod [3];

  assign b0    = $signed(10'(cfg.brightness) - 10'(cfg.contrast));
  // Colors zero and eight take the base level itself as their ramp level.
  assign basev = (in.c[2:0] == 3'd0) ? 11'(b0) : $signed({1'b0, in.base});
  assign grey  = 12'(b0) + 12'(basev);
  assign span  = tvap_span(in.c[3], cfg.contrast);

  // Red, green and blue sit on color bits one, two and zero.
  assign chan_bit = {in.c[0], in.c[2], in.c[1]};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!chan_bit[k]) begin
        term[k] = 12'sd0;
      end else if (cfg.vibrant) begin
        term[k] = $signed({2'b00, span});
      end else begin
        term[k] = 12'(basev);
      end
      dch[k]  = term[k] - 12'(basev);
      prod[k] = 21'(dch[k]) * $signed({13'd0, cfg.saturation});
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int k = 0; k < 3; k++) begin
        s4_p[k] <= prod[k];
      end
      s4_grey <= grey;
      s4_nib  <= in.nib;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k]   = s4_p[k][20] ? 18'(-s4_p[k]) : 18'(s4_p[k]);
      qprod[k] = 37'(mag[k]) * 37'(Recip255);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int k = 0; k < 3; k++) begin
        out.qmag[k] <= qprod[k][Shift255 +: 10];
        out.neg[k]  <= s4_p[k][20];
      end
      out.grey <= s4_grey;
      out.nib  <= s4_nib;
    end
  end

endmodule

// ----- hw/rtl/tvap_post.sv -----
// ----------------------------------------------------------------------------
// tvap_post
// Stage six: restore the sign, add grey and the variant offsets, clamp,
// apply the scanline offset and clamp again into the output register.
// ----------------------------------------------------------------------------
module tvap_post
  import tvap_pkg::*;
(
  input  logic        clk,
  input  cfg_t        cfg,
  input  logic        en,
  input  blend_out_t  in,
  output logic [23:0] rgb
);

  logic signed [10:0] add;
  logic signed [13:0] qs [3];
  logic signed [13:0] sum [3];
  logic [7:0]         lvl [3];
  logic signed [9:0]  scan_sum [3];
  logic [7:0]         fin [3];
  logic               scan_on;

  always_comb begin
    add = 11'sd0;
    if (in.nib[0]) begin
      add = add + 11'(cfg.noise);
    end
    if (in.nib[1]) begin
      add = add + 11'(cfg.ghost);
    end
    // The one-third ghost applies when index bit two is set, except to noise plus ghost.
    if (in.nib[2] && (in.nib[1:0] != 2'b11)) begin
      add = add + 11'(cfg.ghost3);
    end
  end

  assign scan_on = in.nib[3] && cfg.scan_en;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qs[k]       = in.neg[k] ? -$signed({4'd0, in.qmag[k]}) : $signed({4'd0, in.qmag[k]});
      sum[k]      = qs[k] + 14'(in.grey) + 14'(add);
      lvl[k]      = tvap_clamp14(sum[k]);
      scan_sum[k] = $signed({2'b00, lvl[k]}) + 10'(cfg.scanline);
      fin[k]      = scan_on ? tvap_clamp10(scan_sum[k]) : lvl[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rgb <= {fin[2], fin[1], fin[0]};
    end
  end

endmodule

// ----- hw/rtl/tv_artifact_palette_generator.sv -----
// ----------------------------------------------------------------------------
// tv_artifact_palette_generator
// Maps an 8-bit palette index to clamped red, green and blue bytes through a
// six-stage pipeline with per-stage valid bits.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload
//   s_*       in         s_tdata[7:0] palette_index
//   m_*       out        m_tdata[7:0] red, [15:8] green, [23:16] blue
//   cfg_*     in         cfg_index register number, cfg_wr_data value
//
// One request enters per clock unless a stall backs up to the input; each
// result passes every stage in order after its request is accepted. The multipliers of the
// ramp step, the divide by 1000 and the divide by 255 each own a stage.
// Reset (synchronous, active high) clears all valid bits and loads the
// register defaults. A stall holds only the stages that are full behind the
// stalled output; empty stages keep filling, so bubbles are squeezed out.
//
module tv_artifact_palette_generator
  import tvap_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [7:0]               s_tdata,    // [7:0] palette_index
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [23:0]              m_tdata,    // [7:0] red, [15:8] green, [23:16] blue
  input  logic                     cfg_wr_en,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_wr_data
);

  cfg_t cfg;

  logic [6:1] vld;
  logic [6:1] rdy;

  logic [8:0]  ghost_mag;
  logic [16:0] ghost_prod;
  logic [7:0]  ghost_third;
  logic [7:0]  ghost3_next;

  base_out_t  base_q;
  blend_out_t blend_q;

  // One third of the written ghost offset, truncated toward zero. It is
  // stored together with the ghost register in the same write.
  assign ghost_mag   = cfg_wr_data[8] ? 9'(-cfg_wr_data) : cfg_wr_data;
  assign ghost_prod  = 17'(ghost_mag) * 17'(Recip3);
  assign ghost_third = {1'b0, ghost_prod[Shift3 +: 7]};
  assign ghost3_next = cfg_wr_data[8] ? -ghost_third : ghost_third;

  // Configuration registers. Writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.noise      <= '0;
      cfg.ghost      <= '0;
      cfg.ghost3     <= '0;
      cfg.scanline   <= '0;
      cfg.brightness <= BrightnessReset;
      cfg.contrast   <= ContrastReset;
      cfg.saturation <= SaturationReset;
      cfg.inverse    <= 1'b0;
      cfg.vibrant    <= 1'b0;
      cfg.scan_en    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_NOISE:      cfg.noise      <= $signed(cfg_wr_data);
        REG_GHOST: begin
          cfg.ghost  <= $signed(cfg_wr_data);
          cfg.ghost3 <= $signed(ghost3_next);
        end
        REG_SCANLINE:   cfg.scanline   <= $signed(cfg_wr_data);
        REG_BRIGHTNESS: cfg.brightness <= cfg_wr_data[7:0];
        REG_CONTRAST:   cfg.contrast   <= cfg_wr_data[7:0];
        REG_SATURATION: cfg.saturation <= cfg_wr_data[7:0];
        REG_MODE: begin
          cfg.inverse <= cfg_wr_data[0];
          cfg.vibrant <= cfg_wr_data[1];
          cfg.scan_en <= cfg_wr_data[2];
        end
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or when the stage after it moves.
  always_comb begin
    rdy[6] = !vld[6] || m_tready;
    for (int k = 5; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= s_tvalid;
      end
      for (int k = 2; k <= 6; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign s_tready = rdy[1];
  assign m_tvalid = vld[6];

  tvap_base u_base (
    .clk (clk),
    .cfg (cfg),
    .en  (rdy[3:1]),
    .idx (s_tdata),
    .out (base_q)
  );

  tvap_blend u_blend (
    .clk (clk),
    .cfg (cfg),
    .en  (rdy[5:4]),
    .in  (base_q),
    .out (blend_q)
  );

  tvap_post u_post (
    .clk (clk),
    .cfg (cfg),
    .en  (rdy[6]),
    .in  (blend_q),
    .rgb (m_tdata)
  );

endmodule

// ----- test/tv_artifact_palette_generator_tb.sv -----
// ----------------------------------------------------------------------------
// tv_artifact_palette_generator_tb
// Self-checking testbench for the artifact palette generator. A queue-fed
// driver streams palette indexes, a monitor predicts each color triple when
// its request is accepted and checks every returned triple in order, while
// the register file is reprogrammed between drained phases.
// ----------------------------------------------------------------------------
module tv_artifact_palette_generator_tb;
  import tvap_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Index seven has no register behind it; writes there must be dropped.
  localparam logic [2:0] RegUnused = 3'd7;
  localparam int CycleLimit = 200000;
  localparam int NumPhases = 10;
  localparam int ItemsPerPhase = 100;
  localparam int SettleCycles = 20;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [7:0]               s_tdata = '0;      // [7:0] palette_index
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [23:0]              m_tdata;           // [7:0] red, [15:8] green, [23:16] blue
  logic                     cfg_wr_en = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_wr_data = '0;

  // Our own copy of the register file, updated as each write is driven.
  int         noise_ofs;
  int         ghost_ofs;
  int         scan_ofs;
  int         bright_lvl;
  int         contrast_lvl;
  int         sat_lvl;
  logic [2:0] mode_bits;

  logic [7:0]  index_backlog[$];   // palette indexes waiting for the driver
  logic [23:0] rgb_expected[$];    // predicted triples, oldest first
  logic        index_taken = 1'b0; // the request on the bus was accepted
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          cycle_count = 0;
  int          fail_count = 0;
  int          triples_checked = 0;
  int          settings_used = 0;
  string       chan_name[3] = '{"red", "green", "blue"};

  always #6 clk = ~clk;

  tv_artifact_palette_generator u_dut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  function automatic int clamp_byte(input int v);
    return (v > 255) ? 255 : ((v < 0) ? 0 : v);
  endfunction

  // Pull a channel toward the grey level by sat_lvl/255. SystemVerilog
  // integer division truncates toward zero, which is what the block does.
  function automatic int toward_grey(input int chan, input int grey);
    return ((chan - grey) * sat_lvl) / 255 + grey;
  endfunction

  // Color triple for one palette index under the current register settings,
  // packed as {blue, green, red} to line up with m_tdata.
  function automatic logic [23:0] palette_rgb(input logic [7:0] idx);
    int col;
    int lo_base;
    int hi_top;
    int lo_top;
    int top;
    int ramp;
    int level;
    int grey;
    int cr;
    int cg;
    int cb;
    int r;
    int g;
    int b;
    int ofs;
    col     = int'(idx[7:4]);
    lo_base = bright_lvl - contrast_lvl;
    hi_top  = lo_base + contrast_lvl / 2 + 2 * contrast_lvl;
    lo_top  = lo_base + 2 * contrast_lvl;
    // Inverse mode mirrors the low three bits of the color number.
    if (mode_bits[0]) begin
      col = (col & 8) + (7 - (col & 7));
    end
    top   = (col > 7) ? hi_top : lo_top;
    ramp  = (1000 * (top - lo_base)) / 16;
    level = (ramp * ((col & 7) + 9)) / 1000;
    // Black and its bright twin sit on the base level itself.
    if (col == 0 || col == 8) begin
      level = lo_base;
    end
    if (mode_bits[1]) begin
      cb = (col & 1) ? top : lo_base;
      cr = (col & 2) ? top : lo_base;
      cg = (col & 4) ? top : lo_base;
    end else begin
      cb = lo_base + ((col & 1) ? level : 0);
      cr = lo_base + ((col & 2) ? level : 0);
      cg = lo_base + ((col & 4) ? level : 0);
    end
    grey = lo_base + level;
    r = toward_grey(cr, grey);
    g = toward_grey(cg, grey);
    b = toward_grey(cb, grey);
    // Noise and ghost offsets act before the first clamp; the ghost third
    // applies when index bit two is set, except to noise plus ghost.
    ofs = 0;
    if (idx[0]) begin
      ofs += noise_ofs;
    end
    if (idx[1]) begin
      ofs += ghost_ofs;
    end
    if (idx[2] && idx[1:0] != 2'd3) begin
      ofs += ghost_ofs / 3;
    end
    r = clamp_byte(r + ofs);
    g = clamp_byte(g + ofs);
    b = clamp_byte(b + ofs);
    // Scanline entries are offset after clamping and clamped once more.
    if (idx[3] && mode_bits[2]) begin
      r = clamp_byte(r + scan_ofs);
      g = clamp_byte(g + scan_ofs);
      b = clamp_byte(b + scan_ofs);
    end
    return {b[7:0], g[7:0], r[7:0]};
  endfunction

  // Offsets favor the extremes, including the -256 pattern the field allows.
  function automatic logic [8:0] pick_offset();
    logic [8:0] v;
    case ($urandom_range(7))
      0: v = 9'h0FF;
      1: v = 9'h101;
      2: v = 9'h100;
      3: v = 9'h000;
      default: v = 9'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [8:0] pick_level();
    logic [8:0] v;
    case ($urandom_range(5))
      0: v = 9'd0;
      1: v = 9'd255;
      default: v = 9'($urandom_range(255));
    endcase
    return v;
  endfunction

  // Called at a falling edge; the write lands at the next rising edge.
  task automatic set_reg(input logic [2:0] idx, input logic [8:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= value;
    case (idx)
      REG_NOISE:      noise_ofs = int'($signed(value));
      REG_GHOST:      ghost_ofs = int'($signed(value));
      REG_SCANLINE:   scan_ofs = int'($signed(value));
      REG_BRIGHTNESS: bright_lvl = int'(value[7:0]);
      REG_CONTRAST:   contrast_lvl = int'(value[7:0]);
      REG_SATURATION: sat_lvl = int'(value[7:0]);
      REG_MODE:       mode_bits = value[2:0];
      default: begin
      end
    endcase
    @(negedge clk);
  endtask

  // Return at a rising edge once nothing is queued, on the bus or in flight.
  task automatic wait_idle();
    while (index_backlog.size() != 0 || s_tvalid || rgb_expected.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Driver: a new request may replace the current one only after it was
  // accepted, so s_tvalid is reassigned at a falling edge only if it is low or was taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || index_taken) begin
        if (index_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= index_backlog.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts on every accepted request and checks every accepted
  // result against the oldest prediction. It also owns the watchdog.
  always @(posedge clk) begin
    logic [23:0] want;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, rgb_expected.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      index_taken <= !rst && s_tvalid && s_tready;
      if (!rst && s_tvalid && s_tready) begin
        rgb_expected.push_back(palette_rgb(s_tdata));
      end
      if (!rst && m_tvalid && m_tready) begin
        if (rgb_expected.size() == 0) begin
          $error("unexpected result %h with no request outstanding", m_tdata);
          fail_count++;
        end else begin
          want = rgb_expected.pop_front();
          triples_checked++;
          for (int ch = 0; ch < 3; ch++) begin
            if (m_tdata[8*ch +: 8] !== want[8*ch +: 8]) begin
              $error("%s mismatch: expected %0d, actual %0d",
                     chan_name[ch], want[8*ch +: 8], m_tdata[8*ch +: 8]);
              fail_count++;
            end
          end
        end
      end
    end
  end

  // Stimulus: reset, a directed pass at the reset defaults and at one
  // extreme setting, then phases of fresh register values: one at the opposite corner, the rest random.
  initial begin
    noise_ofs    = 0;
    ghost_ofs    = 0;
    scan_ofs     = 0;
    bright_lvl   = int'(BrightnessReset);
    contrast_lvl = int'(ContrastReset);
    sat_lvl      = int'(SaturationReset);
    mode_bits    = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 34;
    recv_idle_pct = 52;
    @(posedge clk);

    // Reset defaults: every color once, its low nibble sweeping all the
    // variant, ghost-third and scanline combinations.
    for (int k = 0; k < 16; k++) begin
      index_backlog.push_back({4'(k), 4'(k)});
    end
    settings_used++;
    wait_idle();
    @(negedge clk);

    // Extreme setting: all modes on, offsets at their limits including the
    // -256 pattern, no brightness, full contrast, no saturation. A write to
    // the unused index must change nothing.
    set_reg(REG_NOISE, 9'h0FF);
    set_reg(REG_GHOST, 9'h100);
    set_reg(REG_SCANLINE, 9'h101);
    set_reg(REG_BRIGHTNESS, 9'd0);
    set_reg(REG_CONTRAST, 9'd255);
    set_reg(REG_SATURATION, 9'd0);
    set_reg(REG_MODE, 9'd7);
    set_reg(RegUnused, 9'h1FF);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    index_backlog.push_back(8'hFF);
    index_backlog.push_back(8'h0F);
    index_backlog.push_back(8'hF4);
    index_backlog.push_back(8'h8B);
    index_backlog.push_back(8'h01);
    index_backlog.push_back(8'h7E);
    index_backlog.push_back(8'h36);
    index_backlog.push_back(8'hC9);
    index_backlog.push_back(8'h52);
    settings_used++;

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      @(negedge clk);
      // The first four phases stall the output more than the input, the
      // next three the other way round, and the last ones run flat out.
      if (ph < 4) begin
        send_idle_pct = 34;
        recv_idle_pct = 52;
      end else if (ph < 7) begin
        send_idle_pct = 52;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == 0) begin
        // Opposite corner from the directed setting.
        set_reg(REG_NOISE, 9'h101);
        set_reg(REG_GHOST, 9'h0FF);
        set_reg(REG_SCANLINE, 9'h0FF);
        set_reg(REG_BRIGHTNESS, 9'd255);
        set_reg(REG_CONTRAST, 9'd255);
        set_reg(REG_SATURATION, 9'd255);
        set_reg(REG_MODE, 9'd4);
      end else begin
        set_reg(REG_NOISE, pick_offset());
        set_reg(REG_GHOST, pick_offset());
        set_reg(REG_SCANLINE, pick_offset());
        set_reg(REG_BRIGHTNESS, pick_level());
        set_reg(REG_CONTRAST, pick_level());
        set_reg(REG_SATURATION, pick_level());
        set_reg(REG_MODE, 9'($urandom_range(7)));
      end
      cfg_wr_en <= 1'b0;
      @(posedge clk);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        index_backlog.push_back(8'($urandom));
      end
      settings_used++;
    end

    wait_idle();
    repeat (SettleCycles) @(posedge clk);
    $display("Checked %0d color triples over %0d register settings,", triples_checked,
             settings_used);
    $display("with input and output stalls in both balances and at full rate.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches found", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
